@@ hw/rtl/imu_frame_parser_unit_defines.svh @@
// Assertion macros used by the IMU frame parser top level
`ifndef IMU_FRAME_PARSER_UNIT_DEFINES_SVH
`define IMU_FRAME_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled while in reset
`define IFP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("imu_frame_parser: check failed");

// Next-cycle implication, checked on clk and disabled while in reset
`define IFP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("imu_frame_parser: check failed");

`endif

@@ hw/rtl/imufp_pkg.sv @@
// Shared types, constants and helpers for the IMU frame parser
`timescale 1ns / 1ps

package imufp_pkg;

    // Frame layout and byte codes
    localparam int unsigned FRAME_BYTES_DEF = 11;
    localparam logic [7:0]  HEADER_BYTE     = 8'h55;
    localparam logic [7:0]  TYPE_RATE       = 8'h52;
    localparam logic [7:0]  TYPE_ORIENT     = 8'h59;

    // Depth of the decoded-frame queue between front and back
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    // Result kind codes
    localparam logic KIND_RATE = 1'b0;
    localparam logic KIND_QUAT = 1'b1;

    // Checked frame handed from front to back: kind and four raw payload words
    typedef struct packed {
        logic        kind;
        logic [15:0] w0;
        logic [15:0] w1;
        logic [15:0] w2;
        logic [15:0] w3;
    } cmd_t;

    // Two's complement negate with -32768 clamped to 32767
    function automatic logic [15:0] neg_sat(input logic [15:0] v);
        logic [15:0] r;
        if (v == 16'h8000) begin
            r = 16'h7FFF;
        end else begin
            r = 16'(~v + 16'd1);
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/imufp_front.sv @@
// Front end: header hunt, byte collection, checksum and frame type check
`timescale 1ns / 1ps

module imufp_front #(
    parameter int unsigned FRAME_BYTES = imufp_pkg::FRAME_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       rx_byte,
    input  logic             q_full,
    output logic             q_push,
    output imufp_pkg::cmd_t  q_cmd
);

    localparam int unsigned STORED = FRAME_BYTES - 2;
    localparam int unsigned CNT_W  = $clog2(FRAME_BYTES);
    localparam int unsigned IDX_W  = $clog2(STORED);
    localparam logic [CNT_W-1:0] CHK_POS = CNT_W'(FRAME_BYTES - 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       store_reg [STORED];
    logic             accept;
    logic             is_idle, is_chk;
    logic [IDX_W-1:0] wr_idx;
    logic             store_wr;
    logic             type_ok;

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;
    assign is_idle  = (count_reg == '0);
    assign is_chk   = (count_reg >= CHK_POS);
    assign wr_idx   = IDX_W'(count_reg - CNT_W'(1));
    assign store_wr = accept && !is_idle && !is_chk;

    // Frame position and running sum
    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        if (accept) begin
            if (is_idle) begin
                if (rx_byte == imufp_pkg::HEADER_BYTE) begin
                    sum_next   = rx_byte;
                    count_next = CNT_W'(1);
                end
            end else if (!is_chk) begin
                sum_next   = 8'(sum_reg + rx_byte);
                count_next = CNT_W'(count_reg + CNT_W'(1));
            end else begin
                count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= '0;
            sum_reg   <= '0;
        end else begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    // Type and payload bytes
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < STORED; i++) begin
            if (store_wr && (wr_idx == IDX_W'(i))) begin
                store_reg[i] <= rx_byte;
            end
        end
    end

    // Checksum byte: hand a good frame of known type to the back end
    assign type_ok = (store_reg[0] == imufp_pkg::TYPE_RATE)
                  || (store_reg[0] == imufp_pkg::TYPE_ORIENT);
    assign q_push  = accept && is_chk && (sum_reg == rx_byte) && type_ok;

    assign q_cmd.kind = (store_reg[0] == imufp_pkg::TYPE_ORIENT) ?
                        imufp_pkg::KIND_QUAT : imufp_pkg::KIND_RATE;
    assign q_cmd.w0   = {store_reg[2], store_reg[1]};
    assign q_cmd.w1   = {store_reg[4], store_reg[3]};
    assign q_cmd.w2   = {store_reg[6], store_reg[5]};
    assign q_cmd.w3   = {store_reg[8], store_reg[7]};

endmodule

@@ hw/rtl/imufp_queue.sv @@
// Short FIFO of checked frames between front and back end
`timescale 1ns / 1ps

module imufp_queue #(
    parameter int unsigned DEPTH = imufp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  imufp_pkg::cmd_t  push_cmd,
    input  logic             pop,
    output imufp_pkg::cmd_t  head_cmd,
    output logic             full,
    output logic             empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    imufp_pkg::cmd_t  mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = mem_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop) begin
            cnt_next = CNT_W'(cnt_reg + 1'b1);
        end else if (do_pop && !do_push) begin
            cnt_next = CNT_W'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ hw/rtl/imufp_back.sv @@
// Back end: mount rotation, saturating negate and the output register
`timescale 1ns / 1ps

module imufp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                mount_flip,
    input  logic                q_empty,
    input  imufp_pkg::cmd_t     head_cmd,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                frame_kind,
    output logic signed [15:0]  value_a,
    output logic signed [15:0]  value_b,
    output logic signed [15:0]  value_c,
    output logic signed [15:0]  value_d
);

    logic        valid_reg, valid_next;
    logic        kind_reg;
    logic [15:0] a_reg, b_reg, c_reg, d_reg;
    logic [15:0] a_next, b_next, c_next, d_next;

    // Load a new item whenever the output register is free or being taken
    assign q_pop = !q_empty && (!valid_reg || !out_stall);

    always_comb
    begin
        valid_next = valid_reg;
        if (q_pop) begin
            valid_next = 1'b1;
        end else if (!out_stall) begin
            valid_next = 1'b0;
        end
    end

    // Field mapping per frame kind and mount
    always_comb
    begin
        if (head_cmd.kind == imufp_pkg::KIND_QUAT) begin
            if (mount_flip) begin
                a_next = imufp_pkg::neg_sat(head_cmd.w1);
                b_next = head_cmd.w0;
                c_next = imufp_pkg::neg_sat(head_cmd.w3);
                d_next = head_cmd.w2;
            end else begin
                a_next = head_cmd.w0;
                b_next = head_cmd.w1;
                c_next = head_cmd.w2;
                d_next = head_cmd.w3;
            end
        end else begin
            a_next = head_cmd.w0;
            b_next = mount_flip ? imufp_pkg::neg_sat(head_cmd.w1) : head_cmd.w1;
            c_next = mount_flip ? imufp_pkg::neg_sat(head_cmd.w2) : head_cmd.w2;
            d_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop) begin
            kind_reg <= head_cmd.kind;
            a_reg    <= a_next;
            b_reg    <= b_next;
            c_reg    <= c_next;
            d_reg    <= d_next;
        end
    end

    assign out_valid  = valid_reg;
    assign frame_kind = kind_reg;
    assign value_a    = signed'(a_reg);
    assign value_b    = signed'(b_reg);
    assign value_c    = signed'(c_reg);
    assign value_d    = signed'(d_reg);

endmodule

@@ hw/rtl/imu_frame_parser_unit.sv @@
// Top level of the IMU serial frame parser
`timescale 1ns / 1ps
`include "imu_frame_parser_unit_defines.svh"

// Takes one received serial byte per item and accepts a byte every cycle unless
// stalled. The front end hunts for the 0x55 header, collects the 11-byte frame
// with a running 8-bit sum and checks the checksum byte; good rate (0x52) and
// quaternion (0x59) frames go into a two-entry queue. The back end applies the
// mount rotation and loads the output register, so a frame passes the queue
// and then the output register before out_valid rises. rx_byte is stalled only
// while the queue holds two frames, which takes a stalled output. Results carry
// raw counts (rate) or Q1.15 words (quaternion); scaling is up to the user.
// Register 0 at byte address 0: bit 0 mount_flip, write only while idle.
module imu_frame_parser_unit #(
    parameter int unsigned FRAME_BYTES = imufp_pkg::FRAME_BYTES_DEF,
    parameter int unsigned QUEUE_DEPTH = imufp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // byte input
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          rx_byte,
    // results
    output logic                out_valid,
    input  logic                out_stall,
    output logic                frame_kind,
    output logic signed [15:0]  value_a,
    output logic signed [15:0]  value_b,
    output logic signed [15:0]  value_c,
    output logic signed [15:0]  value_d
);

    logic             flip_reg, flip_next;
    logic             cfg_sel;
    logic             q_push, q_pop, q_full, q_empty;
    imufp_pkg::cmd_t  push_cmd, head_cmd;

    // Configuration register
    assign pready  = 1'b1;
    assign cfg_sel = (paddr[2] == 1'b0);
    assign prdata  = cfg_sel ? {31'd0, flip_reg} : 32'd0;

    always_comb
    begin
        flip_next = flip_reg;
        if (psel && penable && pwrite && pready && cfg_sel) begin
            flip_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            flip_reg <= 1'b0;
        end else begin
            flip_reg <= flip_next;
        end
    end

    imufp_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    imufp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    imufp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .mount_flip (flip_reg),
        .q_empty    (q_empty),
        .head_cmd   (head_cmd),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .frame_kind (frame_kind),
        .value_a    (value_a),
        .value_b    (value_b),
        .value_c    (value_c),
        .value_d    (value_d)
    );

    // A checked frame never arrives at a full queue
    `IFP_ASSERT_IMP(a_no_overflow, q_push, !q_full)
    // A frame taken from the queue shows up on the output next cycle
    `IFP_ASSERT_NXT(a_pop_to_out, q_pop, out_valid)
    // Rate frames carry no fourth word
    `IFP_ASSERT_IMP(a_rate_d_zero, out_valid && (frame_kind == imufp_pkg::KIND_RATE),
                    value_d == 16'sd0)

endmodule
